/* rtl/jdg_pkg.sv */
`timescale 1ns / 1ps

package jdg_pkg;

   // Field widths of the ports.
   localparam int DAY_NUMBER_W = 24;
   localparam int YEAR_W       = 17;
   localparam int MONTH_W      = 4;
   localparam int DOM_W        = 5;

   // Calendar constants.
   localparam int DAY_OFFSET_X4 = 6884477;
   localparam int DAYS_PER_400Y = 146097;
   localparam int DAYS_PER_100Y = 36525;
   localparam int DAYS_PER_5MON = 153;
   localparam int CENTURY_ROUND = 99;
   localparam int YEARS_PER_CENTURY = 100;

   // The scaled day number is biased by whole 400-year cycles so that it is
   // never negative; the century count is unbiased again in the year.
   localparam int CYCLE_BIAS  = 48;
   localparam int NUM_OFFSET  = CYCLE_BIAS * DAYS_PER_400Y - DAY_OFFSET_X4;
   localparam int YEAR_BIAS   = CYCLE_BIAS * YEARS_PER_CENTURY;

   // Numerator and quotient widths of the four constant divisions.
   localparam int CYC_NUM_W = 27;   // 4 * day number + offset
   localparam int CYC_QUO_W = 9;    // biased centuries, up to 460
   localparam int CYC_REM_W = $clog2(DAYS_PER_400Y);
   localparam int CEN_NUM_W = 22;   // 100 * (r400 / 4) + 99
   localparam int CEN_QUO_W = 7;    // years within the century, up to 99
   localparam int CEN_REM_W = $clog2(DAYS_PER_100Y);
   localparam int DOY_QUO_W = 9;    // day of the March-based year, up to 365
   localparam int MON_NUM_W = 11;   // 5 * day of year + 2
   localparam int MON_QUO_W = 4;    // March-based month, 0 to 11
   localparam int MON_REM_W = $clog2(DAYS_PER_5MON);

   // Division of the month remainder by five: (x * 205) >> 10 is exact
   // for every x below 1024.
   localparam int DIV5_MUL   = 205;
   localparam int DIV5_SHIFT = 10;
   localparam int DIV5_W     = MON_REM_W + DIV5_SHIFT;

   localparam int MONTHS_TO_JAN = 10;   // March-based months from here wrap into the next year

   typedef logic [DAY_NUMBER_W-1:0]  day_number_type;
   typedef logic signed [YEAR_W-1:0] year_type;
   typedef logic [MONTH_W-1:0]       month_type;
   typedef logic [DOM_W-1:0]         dom_type;

   // Data that rides along the later divisions.
   typedef struct packed {
      year_type              year_base;
      logic [CEN_QUO_W-1:0]  years;
   } year_side_type;

endpackage

/* rtl/jdg_if.sv */
`timescale 1ns / 1ps

interface jdg_req_if;
   import jdg_pkg::*;

   logic           valid;
   logic           ready;
   day_number_type day_number;

   modport source (output valid, output day_number, input ready);
   modport sink (input valid, input day_number, output ready);
endinterface

interface jdg_rsp_if;
   import jdg_pkg::*;

   logic      valid;
   logic      ready;
   year_type  year;
   month_type month;
   dom_type   day;

   modport source (output valid, output year, output month, output day, input ready);
   modport sink (input valid, input year, input month, input day, output ready);
endinterface

/* rtl/julian_day_to_gregorian_date.sv */
`timescale 1ns / 1ps

// Channel   Dir   Words                      Handshake
// req_ch    in    day_number (24 bits)       valid / ready
// rsp_ch    out   year (17 s), month, day    valid / ready
//
// One word is accepted every cycle while no stall reaches the input. Eleven
// register stages (offset, century scaling, two for each of the four constant
// divisions, output) carry each word from the input to its result.
// Reset is synchronous and empties every stage.
// Each stage holds its word while the one after it is full and stalled, so
// words move up into bubbles and input is taken while a result waits.

module julian_day_to_gregorian_date (
   input  logic      clock,
   input  logic      reset,
   jdg_req_if.sink   req_ch,
   jdg_rsp_if.source rsp_ch
);
   import jdg_pkg::*;

   localparam int SIDE_W = $bits(year_side_type);

   // Offset stage.
   logic                 a_valid_ff;
   logic [CYC_NUM_W-1:0] a_num_ff, a_num_in;
   logic                 a_ready;

   // Division into centuries.
   logic                 cyc_in_ready, cyc_valid, cyc_ready;
   logic [CYC_QUO_W-1:0] cyc_quo;
   logic [CYC_REM_W-1:0] cyc_rem;

   // Century scaling stage.
   logic                 b_valid_ff;
   logic [CEN_NUM_W-1:0] b_num_ff, b_num_in;
   year_type             b_year_ff, b_year_in;
   logic                 b_ready;

   // Division into years.
   logic                 cen_in_ready, cen_valid, cen_ready;
   logic [CEN_QUO_W-1:0] cen_quo;
   logic [CEN_REM_W-1:0] cen_rem;
   year_type             cen_year;

   // Division into day of year.
   logic                 doy_in_ready, doy_valid, doy_ready;
   logic [DOY_QUO_W-1:0] doy_quo;
   year_side_type        doy_side_in, doy_side;

   // Division into months.
   logic                 mon_in_ready, mon_valid, mon_ready;
   logic [MON_NUM_W-1:0] mon_num;
   logic [MON_QUO_W-1:0] mon_quo;
   logic [MON_REM_W-1:0] mon_rem;
   year_side_type        mon_side;

   // Output register.
   logic                 o_valid_ff;
   year_type             o_year_ff, o_year_in;
   month_type            o_month_ff, o_month_in;
   dom_type              o_day_ff, o_day_in;
   logic                 o_ready;
   logic                 carry;
   logic [YEAR_W-1:0]    year_sum;
   logic [DIV5_W-1:0]    day_prod;

   // Offset stage.
   assign a_num_in = (CYC_NUM_W'(req_ch.day_number) << 2) + CYC_NUM_W'(NUM_OFFSET);
   assign a_ready  = !a_valid_ff || cyc_in_ready;
   assign req_ch.ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_ch.valid;
      end
      if (a_ready && req_ch.valid) begin
         a_num_ff <= a_num_in;
      end
   end

   jdg_cdiv #(
      .NUM_W   (CYC_NUM_W),
      .QUO_W   (CYC_QUO_W),
      .DIVISOR (DAYS_PER_400Y),
      .SIDE_W  (1)
   ) u_cyc_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_ready  (cyc_in_ready),
      .num_i     (a_num_ff),
      .side_i    (1'b0),
      .out_valid (cyc_valid),
      .out_ready (cyc_ready),
      .quo_o     (cyc_quo),
      .rem_o     (cyc_rem),
      .side_o    ()
   );

   // Century scaling; the century count becomes the year base, unbiased.
   assign b_num_in  = CEN_NUM_W'(cyc_rem[CYC_REM_W-1:2]) * CEN_NUM_W'(YEARS_PER_CENTURY)
                      + CEN_NUM_W'(CENTURY_ROUND);
   assign b_year_in = year_type'(YEAR_W'(cyc_quo) * YEAR_W'(YEARS_PER_CENTURY)
                      - YEAR_W'(YEAR_BIAS));
   assign b_ready   = !b_valid_ff || cen_in_ready;
   assign cyc_ready = b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= cyc_valid;
      end
      if (b_ready && cyc_valid) begin
         b_num_ff  <= b_num_in;
         b_year_ff <= b_year_in;
      end
   end

   jdg_cdiv #(
      .NUM_W   (CEN_NUM_W),
      .QUO_W   (CEN_QUO_W),
      .DIVISOR (DAYS_PER_100Y),
      .SIDE_W  (YEAR_W)
   ) u_cen_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_ready  (cen_in_ready),
      .num_i     (b_num_ff),
      .side_i    (b_year_ff),
      .out_valid (cen_valid),
      .out_ready (cen_ready),
      .quo_o     (cen_quo),
      .rem_o     (cen_rem),
      .side_o    (cen_year)
   );

   assign doy_side_in.year_base = cen_year;
   assign doy_side_in.years     = cen_quo;

   jdg_cdiv #(
      .NUM_W   (CEN_REM_W),
      .QUO_W   (DOY_QUO_W),
      .DIVISOR (YEARS_PER_CENTURY),
      .SIDE_W  (SIDE_W)
   ) u_doy_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cen_valid),
      .in_ready  (doy_in_ready),
      .num_i     (cen_rem),
      .side_i    (doy_side_in),
      .out_valid (doy_valid),
      .out_ready (doy_ready),
      .quo_o     (doy_quo),
      .rem_o     (),
      .side_o    (doy_side)
   );

   assign cen_ready = doy_in_ready;

   // Five times the day of year plus two, as a shift and add.
   assign mon_num = (MON_NUM_W'(doy_quo) << 2) + MON_NUM_W'(doy_quo) + MON_NUM_W'(2);

   jdg_cdiv #(
      .NUM_W   (MON_NUM_W),
      .QUO_W   (MON_QUO_W),
      .DIVISOR (DAYS_PER_5MON),
      .SIDE_W  (SIDE_W)
   ) u_mon_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (doy_valid),
      .in_ready  (mon_in_ready),
      .num_i     (mon_num),
      .side_i    (doy_side),
      .out_valid (mon_valid),
      .out_ready (mon_ready),
      .quo_o     (mon_quo),
      .rem_o     (mon_rem),
      .side_o    (mon_side)
   );

   assign doy_ready = mon_in_ready;

   // Fold March-based months into January to December; January and
   // February belong to the next year.
   assign carry    = (mon_quo >= MON_QUO_W'(MONTHS_TO_JAN));
   assign day_prod = DIV5_W'(mon_rem) * DIV5_W'(DIV5_MUL);
   assign year_sum = YEAR_W'(mon_side.year_base) + YEAR_W'(mon_side.years) + YEAR_W'(carry);

   always_comb begin
      if (carry) begin
         o_month_in = mon_quo - MON_QUO_W'(9);
      end else begin
         o_month_in = mon_quo + MON_QUO_W'(3);
      end
      o_day_in = DOM_W'(day_prod >> DIV5_SHIFT) + DOM_W'(1);
      // There is no year zero: astronomical year 0 is 1 BC, shown as -1.
      if (year_sum[YEAR_W-1] || (year_sum == '0)) begin
         o_year_in = year_type'(year_sum - YEAR_W'(1));
      end else begin
         o_year_in = year_type'(year_sum);
      end
   end

   assign o_ready   = !o_valid_ff || rsp_ch.ready;
   assign mon_ready = o_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= mon_valid;
      end
      if (o_ready && mon_valid) begin
         o_year_ff  <= o_year_in;
         o_month_ff <= o_month_in;
         o_day_ff   <= o_day_in;
      end
   end

   assign rsp_ch.valid = o_valid_ff;
   assign rsp_ch.year  = o_year_ff;
   assign rsp_ch.month = o_month_ff;
   assign rsp_ch.day   = o_day_ff;

endmodule

/* rtl/jdg_cdiv.sv */
`timescale 1ns / 1ps

module jdg_cdiv #(
   parameter int NUM_W   = 16,
   parameter int QUO_W   = 8,
   parameter int DIVISOR = 100,
   parameter int SIDE_W  = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [NUM_W-1:0]            num_i,
   input  logic [SIDE_W-1:0]           side_i,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [QUO_W-1:0]            quo_o,
   output logic [$clog2(DIVISOR)-1:0]  rem_o,
   output logic [SIDE_W-1:0]           side_o
);
   localparam int    REM_W   = $clog2(DIVISOR);
   localparam longint RECIP  = (64'd1 << NUM_W) / DIVISOR;
   localparam int    RECIP_W = $clog2(RECIP + 1);
   localparam int    PROD_W  = NUM_W + RECIP_W;

   // Estimate stage: the scaled reciprocal gives the true quotient or one less,
   // because the numerator stays below 2**NUM_W.
   logic              est_valid_ff;
   logic [NUM_W-1:0]  est_num_ff;
   logic [QUO_W-1:0]  est_quo_ff, est_quo_in;
   logic [SIDE_W-1:0] est_side_ff;
   logic [PROD_W-1:0] prod;
   logic              est_ready;

   // Correction stage.
   logic              cor_valid_ff;
   logic [QUO_W-1:0]  cor_quo_ff, cor_quo_in;
   logic [REM_W-1:0]  cor_rem_ff, cor_rem_in;
   logic [SIDE_W-1:0] cor_side_ff;
   logic [NUM_W-1:0]  quo_times_div;
   logic [NUM_W-1:0]  diff;
   logic [REM_W:0]    rem_est;
   logic              cor_ready;

   assign prod       = PROD_W'(num_i) * PROD_W'(RECIP);
   assign est_quo_in = prod[NUM_W +: QUO_W];

   assign cor_ready = !cor_valid_ff || out_ready;
   assign est_ready = !est_valid_ff || cor_ready;
   assign in_ready  = est_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         est_valid_ff <= 1'b0;
      end else if (est_ready) begin
         est_valid_ff <= in_valid;
      end
      if (est_ready && in_valid) begin
         est_num_ff  <= num_i;
         est_quo_ff  <= est_quo_in;
         est_side_ff <= side_i;
      end
   end

   assign quo_times_div = NUM_W'(est_quo_ff) * NUM_W'(DIVISOR);
   assign diff          = est_num_ff - quo_times_div;
   assign rem_est       = diff[REM_W:0];

   always_comb begin
      if (rem_est >= (REM_W + 1)'(DIVISOR)) begin
         cor_quo_in = est_quo_ff + QUO_W'(1);
         cor_rem_in = REM_W'(rem_est - (REM_W + 1)'(DIVISOR));
      end else begin
         cor_quo_in = est_quo_ff;
         cor_rem_in = rem_est[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cor_valid_ff <= 1'b0;
      end else if (cor_ready) begin
         cor_valid_ff <= est_valid_ff;
      end
      if (cor_ready && est_valid_ff) begin
         cor_quo_ff  <= cor_quo_in;
         cor_rem_ff  <= cor_rem_in;
         cor_side_ff <= est_side_ff;
      end
   end

   assign out_valid = cor_valid_ff;
   assign quo_o     = cor_quo_ff;
   assign rem_o     = cor_rem_ff;
   assign side_o    = cor_side_ff;

endmodule

/* rtl/jdg_checker.sv */
`timescale 1ns / 1ps

module jdg_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input jdg_pkg::year_type       rsp_year,
   input jdg_pkg::month_type      rsp_month,
   input jdg_pkg::dom_type        rsp_day
);
   import jdg_pkg::*;

   localparam int STAGES = 11;
   localparam int CNT_W  = $clog2(STAGES + 1);

   logic [CNT_W-1:0] pending_ff, pending_in;
   logic             req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + CNT_W'(1);
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_year)
         && $stable(rsp_month) && $stable(rsp_day))
      else $error("result word changed while stalled");

   // Every result belongs to an accepted word, and no more words are in
   // flight than the pipeline has stages.
   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      (pending_ff <= CNT_W'(STAGES)) && (!rsp_valid || (pending_ff != '0)))
      else $error("words in flight out of range");

   // With the output register empty, nothing ahead of it can block input.
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with an empty output");

   // Results are proper calendar values.
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= month_type'(1)) && (rsp_month <= month_type'(12))
         && (rsp_day != '0) && (rsp_year != '0))
      else $error("result date out of range");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind julian_day_to_gregorian_date jdg_checker u_jdg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_year  (rsp_ch.year),
   .rsp_month (rsp_ch.month),
   .rsp_day   (rsp_ch.day)
);
